// ===== rtl/lcdseq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types and constants of the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

    localparam int MaxResults = 13;
    localparam int CntW       = 4;

    localparam logic [7:0] LcdEn     = 8'h08;
    localparam logic [7:0] LcdRw     = 8'h04;
    localparam logic [7:0] LcdRs     = 8'h02;
    localparam logic [7:0] DirLowOut = 8'h0f;
    localparam logic [7:0] DirAllOut = 8'hff;
    localparam logic [7:0] PatReset8 = 8'h30;
    localparam logic [7:0] PatMode4  = 8'h20;
    localparam logic [7:0] InsClear  = 8'h01;
    localparam logic [7:0] InsHome   = 8'h02;

    localparam logic [1:0] ActInit  = 2'd0;
    localparam logic [1:0] ActInstr = 2'd1;
    localparam logic [1:0] ActChar  = 2'd2;
    localparam logic [1:0] ActPort  = 2'd3;

    localparam logic [1:0] KindPort = 2'd0;
    localparam logic [1:0] KindDir  = 2'd1;
    localparam logic [1:0] KindRead = 2'd2;

    localparam logic [1:0] CfgFunctionSet    = 2'd0;
    localparam logic [1:0] CfgDisplayControl = 2'd1;
    localparam logic [1:0] CfgEntryMode      = 2'd2;

    localparam logic [7:0] RstFunctionSet    = 8'h28;
    localparam logic [7:0] RstDisplayControl = 8'h0c;
    localparam logic [7:0] RstEntryMode      = 8'h06;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'b001,
        PH_WAIT      = 3'b010,
        PH_INIT_WAIT = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } t_entry;

    typedef struct packed {
        t_entry [MaxResults-1:0] ent;
        logic [CntW-1:0]         cnt;
    } t_burst;

endpackage

// ===== rtl/char_lcd_nibble_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Turns init, instruction, character and port-sample requests into bursts of
// port, direction and read-request transactions for a 4-bit character LCD.
//
// Channel  Direction  Handshake                  Payload
// in       sink       i_in_valid / o_in_ready    i_action, i_data_byte, i_port_read
// out      source     o_out_valid / i_out_ready  o_out_kind, o_out_value, o_last
// cfg      sink       i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A request is decoded in the cycle it is taken; its burst of 0..13 results is
// held in a shift register and leaves one result per cycle while i_out_ready is high.
// Results leave through the single output port; a request whose burst has no
// result leaves the input ready for the next request.
// The next request is taken in the cycle the last result of the previous one
// leaves. Synchronous active-low reset clears state and restores the config.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_port_read,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_value,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    function automatic lcdseq_pkg::t_burst f_put(lcdseq_pkg::t_burst b,
                                                 logic [1:0] kind,
                                                 logic [7:0] value);
        lcdseq_pkg::t_burst r;
        r = b;
        if (b.cnt < lcdseq_pkg::CntW'(lcdseq_pkg::MaxResults)) begin
            r.ent[b.cnt].kind  = kind;
            r.ent[b.cnt].value = value;
            r.cnt              = b.cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic lcdseq_pkg::t_burst f_read_cycle(lcdseq_pkg::t_burst b);
        lcdseq_pkg::t_burst r;
        r = f_put(b, lcdseq_pkg::KindPort, lcdseq_pkg::LcdRw);
        r = f_put(r, lcdseq_pkg::KindPort, lcdseq_pkg::LcdRw | lcdseq_pkg::LcdEn);
        r = f_put(r, lcdseq_pkg::KindRead, 8'h00);
        return r;
    endfunction

    function automatic lcdseq_pkg::t_burst f_strobe(lcdseq_pkg::t_burst b,
                                                    logic [7:0] v);
        lcdseq_pkg::t_burst r;
        r = f_put(b, lcdseq_pkg::KindPort, v);
        r = f_put(r, lcdseq_pkg::KindPort, v | lcdseq_pkg::LcdEn);
        r = f_put(r, lcdseq_pkg::KindPort, v);
        return r;
    endfunction

    function automatic lcdseq_pkg::t_burst f_start_wait(lcdseq_pkg::t_burst b);
        lcdseq_pkg::t_burst r;
        r = f_put(b, lcdseq_pkg::KindDir, lcdseq_pkg::DirLowOut);
        r = f_read_cycle(r);
        return r;
    endfunction

    logic [7:0]           r_cfg_fs, r_cfg_dc, r_cfg_em;
    lcdseq_pkg::t_phase   r_phase, n_phase;
    logic [7:0]           r_pend_byte, n_pend_byte;
    logic                 r_pend_sel, n_pend_sel;
    logic [2:0]           r_init_step, n_init_step;
    lcdseq_pkg::t_burst   r_burst, n_burst;

    logic                 in_acc;
    logic                 out_acc;
    logic [7:0]           rs_bits;
    logic [7:0]           next_instr;
    lcdseq_pkg::t_burst   b;

    assign o_out_valid = (r_burst.cnt != '0);
    assign o_out_kind  = r_burst.ent[0].kind;
    assign o_out_value = r_burst.ent[0].value;
    assign o_last      = (r_burst.cnt == lcdseq_pkg::CntW'(1));
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_in_ready  = !o_out_valid || (out_acc && o_last);
    assign in_acc      = i_in_valid && o_in_ready;

    assign rs_bits = r_pend_sel ? lcdseq_pkg::LcdRs : 8'h00;

    always_comb begin
        unique case (r_init_step)
            3'd0:    next_instr = r_cfg_fs;
            3'd1:    next_instr = r_cfg_dc;
            3'd2:    next_instr = r_cfg_em;
            3'd3:    next_instr = lcdseq_pkg::InsClear;
            default: next_instr = lcdseq_pkg::InsHome;
        endcase
    end

    always_comb begin
        b           = '0;
        n_phase     = r_phase;
        n_pend_byte = r_pend_byte;
        n_pend_sel  = r_pend_sel;
        n_init_step = r_init_step;
        unique case (r_phase)
            lcdseq_pkg::PH_WAIT: begin
                if (i_action == lcdseq_pkg::ActPort) begin
                    b = f_put(b, lcdseq_pkg::KindPort, lcdseq_pkg::LcdRw);
                    b = f_put(b, lcdseq_pkg::KindPort,
                              lcdseq_pkg::LcdRw | lcdseq_pkg::LcdEn);
                    if (i_port_read[7]) begin
                        b = f_read_cycle(b);
                    end else begin
                        b = f_put(b, lcdseq_pkg::KindDir, lcdseq_pkg::DirAllOut);
                        b = f_strobe(b, {r_pend_byte[7:4], 4'h0} | rs_bits);
                        b = f_strobe(b, {r_pend_byte[3:0], 4'h0} | rs_bits);
                        n_phase = lcdseq_pkg::PH_IDLE;
                        if (r_init_step >= 3'd1 && r_init_step <= 3'd4) begin
                            n_init_step = r_init_step + 3'd1;
                            n_pend_byte = next_instr;
                            n_pend_sel  = 1'b0;
                            b           = f_start_wait(b);
                            n_phase     = lcdseq_pkg::PH_WAIT;
                        end else begin
                            n_init_step = 3'd0;
                        end
                    end
                end
            end
            lcdseq_pkg::PH_INIT_WAIT: begin
                if (i_action == lcdseq_pkg::ActPort) begin
                    b = f_put(b, lcdseq_pkg::KindPort, lcdseq_pkg::LcdRw);
                    if (i_port_read[7]) begin
                        b = f_read_cycle(b);
                    end else begin
                        b           = f_strobe(b, lcdseq_pkg::PatMode4);
                        n_init_step = 3'd1;
                        n_pend_byte = r_cfg_fs;
                        n_pend_sel  = 1'b0;
                        b           = f_start_wait(b);
                        n_phase     = lcdseq_pkg::PH_WAIT;
                    end
                end
            end
            default: begin
                n_phase = lcdseq_pkg::PH_IDLE;
                if (i_action == lcdseq_pkg::ActInit) begin
                    b = f_put(b, lcdseq_pkg::KindDir, lcdseq_pkg::DirAllOut);
                    b = f_strobe(b, lcdseq_pkg::PatReset8);
                    b = f_strobe(b, 8'h00);
                    b = f_read_cycle(b);
                    n_init_step = 3'd0;
                    n_phase     = lcdseq_pkg::PH_INIT_WAIT;
                end else if (i_action == lcdseq_pkg::ActInstr ||
                             i_action == lcdseq_pkg::ActChar) begin
                    n_init_step = 3'd0;
                    n_pend_byte = i_data_byte;
                    n_pend_sel  = (i_action == lcdseq_pkg::ActChar);
                    b           = f_start_wait(b);
                    n_phase     = lcdseq_pkg::PH_WAIT;
                end
            end
        endcase
    end

    // advance the result shift register, or load a fresh burst
    always_comb begin
        n_burst = r_burst;
        if (in_acc) begin
            n_burst = b;
        end else if (out_acc) begin
            n_burst.ent = {lcdseq_pkg::t_entry'('0),
                           r_burst.ent[lcdseq_pkg::MaxResults-1:1]};
            n_burst.cnt = r_burst.cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fs    <= lcdseq_pkg::RstFunctionSet;
            r_cfg_dc    <= lcdseq_pkg::RstDisplayControl;
            r_cfg_em    <= lcdseq_pkg::RstEntryMode;
            r_phase     <= lcdseq_pkg::PH_IDLE;
            r_pend_byte <= 8'h00;
            r_pend_sel  <= 1'b0;
            r_init_step <= 3'd0;
            r_burst     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lcdseq_pkg::CfgFunctionSet:    r_cfg_fs <= i_cfg_data;
                    lcdseq_pkg::CfgDisplayControl: r_cfg_dc <= i_cfg_data;
                    lcdseq_pkg::CfgEntryMode:      r_cfg_em <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_phase     <= n_phase;
                r_pend_byte <= n_pend_byte;
                r_pend_sel  <= n_pend_sel;
                r_init_step <= n_init_step;
            end
            r_burst <= n_burst;
        end
    end

endmodule
